>>> rtl/hsvrgb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// Shared types and codes for the HSV to RGB converter pipeline.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

    typedef logic [2:0] t_sector;

    localparam t_sector SEC_RED_YELLOW    = 3'd0;
    localparam t_sector SEC_YELLOW_GREEN  = 3'd1;
    localparam t_sector SEC_GREEN_CYAN    = 3'd2;
    localparam t_sector SEC_CYAN_BLUE     = 3'd3;
    localparam t_sector SEC_BLUE_MAGENTA  = 3'd4;
    localparam t_sector SEC_MAGENTA_RED   = 3'd5;

    typedef struct packed {
        logic    gray;
        t_sector sector;
    } t_route_info;

endpackage

>>> rtl/hsvrgb_hue_split.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvrgb_hue_split
// First stage: scales hue by six into sector and fraction, forms the
// complements of fraction and saturation, flags zero saturation.
// ----------------------------------------------------------------------------
module hsvrgb_hue_split #(
    parameter int HUE_BITS     = 16,
    parameter int CHANNEL_BITS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [HUE_BITS-1:0]           i_hue,
    input  logic [CHANNEL_BITS-1:0]       i_saturation,
    input  logic [CHANNEL_BITS-1:0]       i_value,
    output logic [HUE_BITS-1:0]           o_frac,
    output logic [HUE_BITS:0]             o_frac_inv,
    output logic [CHANNEL_BITS-1:0]       o_sat,
    output logic [CHANNEL_BITS-1:0]       o_sat_inv,
    output logic [CHANNEL_BITS-1:0]       o_value,
    output hsvrgb_pkg::t_route_info       o_info
);

    localparam int HB = HUE_BITS;
    localparam int CB = CHANNEL_BITS;
    localparam logic [CB-1:0] FULL  = {CB{1'b1}};
    localparam logic [HB:0]   TURN  = {1'b1, {HB{1'b0}}};

    logic [HB+2:0]            n_h6;
    logic [HB-1:0]            r_frac;
    logic [HB:0]              r_frac_inv;
    logic [CB-1:0]            r_sat;
    logic [CB-1:0]            r_sat_inv;
    logic [CB-1:0]            r_value;
    hsvrgb_pkg::t_route_info  r_info;

    assign n_h6 = ({3'b000, i_hue} << 2) + ({3'b000, i_hue} << 1);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_frac        <= n_h6[HB-1:0];
            r_frac_inv    <= TURN - {1'b0, n_h6[HB-1:0]};
            r_sat         <= i_saturation;
            r_sat_inv     <= FULL - i_saturation;
            r_value       <= i_value;
            r_info.sector <= n_h6[HB+2:HB];
            r_info.gray   <= (i_saturation == '0);
        end
    end

    assign o_frac     = r_frac;
    assign o_frac_inv = r_frac_inv;
    assign o_sat      = r_sat;
    assign o_sat_inv  = r_sat_inv;
    assign o_value    = r_value;
    assign o_info     = r_info;

endmodule

>>> rtl/hsvrgb_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvrgb_mul
// Four stages: s*f products, complement against full scale, value products
// split in high and low halves, then fold back and drop the hue fraction.
// Outputs the numerators of p, q and t ahead of the divide by full scale.
// ----------------------------------------------------------------------------
module hsvrgb_mul #(
    parameter int HUE_BITS     = 16,
    parameter int CHANNEL_BITS = 8
) (
    input  logic                          i_clk,
    input  logic [3:0]                    i_en,
    input  logic [HUE_BITS-1:0]           i_frac,
    input  logic [HUE_BITS:0]             i_frac_inv,
    input  logic [CHANNEL_BITS-1:0]       i_sat,
    input  logic [CHANNEL_BITS-1:0]       i_sat_inv,
    input  logic [CHANNEL_BITS-1:0]       i_value,
    input  hsvrgb_pkg::t_route_info       i_info,
    output logic [2*CHANNEL_BITS-1:0]     o_num_p,
    output logic [2*CHANNEL_BITS-1:0]     o_num_q,
    output logic [2*CHANNEL_BITS-1:0]     o_num_t,
    output logic [CHANNEL_BITS-1:0]       o_value,
    output hsvrgb_pkg::t_route_info       o_info
);

    localparam int HB = HUE_BITS;
    localparam int CB = CHANNEL_BITS;
    localparam int XW = CB + HB;
    localparam logic [XW-1:0] DEN = {{CB{1'b1}}, {HB{1'b0}}};

    // stage A
    logic [XW:0]              n_sfb_full;
    logic [XW-1:0]            r_sf;
    logic [XW-1:0]            r_sfb;
    logic [2*CB-1:0]          r_pn_a;
    logic [CB-1:0]            r_v_a;
    hsvrgb_pkg::t_route_info  r_info_a;
    // stage B
    logic [XW-1:0]            r_xq;
    logic [XW-1:0]            r_xt;
    logic [2*CB-1:0]          r_pn_b;
    logic [CB-1:0]            r_v_b;
    hsvrgb_pkg::t_route_info  r_info_b;
    // stage C
    logic [2*CB-1:0]          r_qhi;
    logic [XW-1:0]            r_qlo;
    logic [2*CB-1:0]          r_thi;
    logic [XW-1:0]            r_tlo;
    logic [2*CB-1:0]          r_pn_c;
    logic [CB-1:0]            r_v_c;
    hsvrgb_pkg::t_route_info  r_info_c;
    // stage D
    logic [2*CB-1:0]          r_yq;
    logic [2*CB-1:0]          r_yt;
    logic [2*CB-1:0]          r_pn_d;
    logic [CB-1:0]            r_v_d;
    hsvrgb_pkg::t_route_info  r_info_d;

    assign n_sfb_full = {{(HB+1){1'b0}}, i_sat} * {{CB{1'b0}}, i_frac_inv};

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_sf     <= {{HB{1'b0}}, i_sat} * {{CB{1'b0}}, i_frac};
            r_sfb    <= n_sfb_full[XW-1:0];
            r_pn_a   <= {{CB{1'b0}}, i_value} * {{CB{1'b0}}, i_sat_inv};
            r_v_a    <= i_value;
            r_info_a <= i_info;
        end
        if (i_en[1]) begin
            r_xq     <= DEN - r_sf;
            r_xt     <= DEN - r_sfb;
            r_pn_b   <= r_pn_a;
            r_v_b    <= r_v_a;
            r_info_b <= r_info_a;
        end
        if (i_en[2]) begin
            r_qhi    <= {{CB{1'b0}}, r_v_b} * {{CB{1'b0}}, r_xq[XW-1:HB]};
            r_qlo    <= {{HB{1'b0}}, r_v_b} * {{CB{1'b0}}, r_xq[HB-1:0]};
            r_thi    <= {{CB{1'b0}}, r_v_b} * {{CB{1'b0}}, r_xt[XW-1:HB]};
            r_tlo    <= {{HB{1'b0}}, r_v_b} * {{CB{1'b0}}, r_xt[HB-1:0]};
            r_pn_c   <= r_pn_b;
            r_v_c    <= r_v_b;
            r_info_c <= r_info_b;
        end
        if (i_en[3]) begin
            r_yq     <= r_qhi + {{CB{1'b0}}, r_qlo[XW-1:HB]};
            r_yt     <= r_thi + {{CB{1'b0}}, r_tlo[XW-1:HB]};
            r_pn_d   <= r_pn_c;
            r_v_d    <= r_v_c;
            r_info_d <= r_info_c;
        end
    end

    assign o_num_p = r_pn_d;
    assign o_num_q = r_yq;
    assign o_num_t = r_yt;
    assign o_value = r_v_d;
    assign o_info  = r_info_d;

endmodule

>>> rtl/hsvrgb_div_m.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvrgb_div_m
// Two-stage divide by full scale (2^CHANNEL_BITS - 1): estimate by
// shift-add, then correct by up to two using the remainder.
// Dividend must not exceed full scale squared.
// ----------------------------------------------------------------------------
module hsvrgb_div_m #(
    parameter int CHANNEL_BITS = 8
) (
    input  logic                          i_clk,
    input  logic [1:0]                    i_en,
    input  logic [2*CHANNEL_BITS-1:0]     i_num,
    output logic [CHANNEL_BITS-1:0]       o_quot
);

    localparam int CB = CHANNEL_BITS;
    localparam logic [CB+1:0] FULL_X1 = {2'b00, {CB{1'b1}}};
    localparam logic [CB+1:0] FULL_X2 = {1'b0, {CB{1'b1}}, 1'b0};

    logic [2*CB-1:0] n_sum;
    logic [CB-1:0]   n_est;
    logic [2*CB-1:0] n_rem;
    logic [CB-1:0]   r_est;
    logic [CB+1:0]   r_rem;
    logic [CB-1:0]   r_quot;

    assign n_sum = i_num + {{CB{1'b0}}, i_num[2*CB-1:CB]};
    assign n_est = n_sum[2*CB-1:CB];
    assign n_rem = i_num - {n_est, {CB{1'b0}}} + {{CB{1'b0}}, n_est};

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_est <= n_est;
            r_rem <= n_rem[CB+1:0];
        end
        if (i_en[1]) begin
            if (r_rem >= FULL_X2) begin
                r_quot <= r_est + CB'(2);
            end else if (r_rem >= FULL_X1) begin
                r_quot <= r_est + CB'(1);
            end else begin
                r_quot <= r_est;
            end
        end
    end

    assign o_quot = r_quot;

endmodule

>>> rtl/hsv_to_rgb_converter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_core
// HSV to RGB pixel converter, eight-stage pipeline.
//
// Slave channel takes one pixel per request: hue (fraction of a turn),
// saturation and value. Master channel returns red, green and blue.
// Zero saturation gives grey equal to value; otherwise p, q and t are
// formed from value and routed by hue sector, truncated toward zero.
// Stages from input request to output valid: one for the hue split,
// four for the multiplies and fold, two for the divide by full scale,
// one for the sector routing and output register.
// Throughput is one pixel per clock unless the receiver stalls with the pipeline full; every stage holds a valid bit.
// When the receiver stalls, the output register holds its pixel and
// upstream stages keep filling empty slots, so input stays ready until
// the pipeline is full. Nothing is dropped or repeated.
// Synchronous active-low reset clears all valid bits; no pixel is output
// until a new one is accepted.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_core #(
    parameter int HUE_BITS     = 16,
    parameter int CHANNEL_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // hue, saturation, value; zero padded to bytes
    input  logic [((HUE_BITS+2*CHANNEL_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // red, green, blue; zero padded to bytes
    output logic [((3*CHANNEL_BITS+7)/8)*8-1:0]          o_m_axis_tdata
);

    localparam int HB         = HUE_BITS;
    localparam int CB         = CHANNEL_BITS;
    localparam int OUT_W      = ((3*CB+7)/8)*8;
    localparam int NUM_STAGES = 8;

    logic [NUM_STAGES-1:0]    r_vld;
    logic [NUM_STAGES-1:0]    n_en;

    logic [HB-1:0]            w_frac;
    logic [HB:0]              w_frac_inv;
    logic [CB-1:0]            w_sat;
    logic [CB-1:0]            w_sat_inv;
    logic [CB-1:0]            w_value1;
    hsvrgb_pkg::t_route_info  w_info1;

    logic [2*CB-1:0]          w_num_p;
    logic [2*CB-1:0]          w_num_q;
    logic [2*CB-1:0]          w_num_t;
    logic [CB-1:0]            w_value5;
    hsvrgb_pkg::t_route_info  w_info5;

    logic [CB-1:0]            w_p;
    logic [CB-1:0]            w_q;
    logic [CB-1:0]            w_t;

    logic [CB-1:0]            r_v6;
    logic [CB-1:0]            r_v7;
    hsvrgb_pkg::t_route_info  r_info6;
    hsvrgb_pkg::t_route_info  r_info7;

    logic [CB-1:0]            r_red;
    logic [CB-1:0]            r_green;
    logic [CB-1:0]            r_blue;
    logic [CB-1:0]            n_red;
    logic [CB-1:0]            n_green;
    logic [CB-1:0]            n_blue;

    always_comb begin
        n_en[NUM_STAGES-1] = ~r_vld[NUM_STAGES-1] | i_m_axis_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            n_en[k] = ~r_vld[k] | n_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (n_en[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (n_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    hsvrgb_hue_split #(
        .HUE_BITS     (HB),
        .CHANNEL_BITS (CB)
    ) u_hue_split (
        .i_clk        (i_clk),
        .i_en         (n_en[0]),
        .i_hue        (i_s_axis_tdata[HB-1:0]),
        .i_saturation (i_s_axis_tdata[HB+CB-1:HB]),
        .i_value      (i_s_axis_tdata[HB+2*CB-1:HB+CB]),
        .o_frac       (w_frac),
        .o_frac_inv   (w_frac_inv),
        .o_sat        (w_sat),
        .o_sat_inv    (w_sat_inv),
        .o_value      (w_value1),
        .o_info       (w_info1)
    );

    hsvrgb_mul #(
        .HUE_BITS     (HB),
        .CHANNEL_BITS (CB)
    ) u_mul (
        .i_clk        (i_clk),
        .i_en         (n_en[4:1]),
        .i_frac       (w_frac),
        .i_frac_inv   (w_frac_inv),
        .i_sat        (w_sat),
        .i_sat_inv    (w_sat_inv),
        .i_value      (w_value1),
        .i_info       (w_info1),
        .o_num_p      (w_num_p),
        .o_num_q      (w_num_q),
        .o_num_t      (w_num_t),
        .o_value      (w_value5),
        .o_info       (w_info5)
    );

    hsvrgb_div_m #(.CHANNEL_BITS(CB)) u_div_p (
        .i_clk  (i_clk),
        .i_en   (n_en[6:5]),
        .i_num  (w_num_p),
        .o_quot (w_p)
    );

    hsvrgb_div_m #(.CHANNEL_BITS(CB)) u_div_q (
        .i_clk  (i_clk),
        .i_en   (n_en[6:5]),
        .i_num  (w_num_q),
        .o_quot (w_q)
    );

    hsvrgb_div_m #(.CHANNEL_BITS(CB)) u_div_t (
        .i_clk  (i_clk),
        .i_en   (n_en[6:5]),
        .i_num  (w_num_t),
        .o_quot (w_t)
    );

    always_ff @(posedge i_clk) begin
        if (n_en[5]) begin
            r_v6    <= w_value5;
            r_info6 <= w_info5;
        end
        if (n_en[6]) begin
            r_v7    <= r_v6;
            r_info7 <= r_info6;
        end
    end

    always_comb begin
        n_red   = r_v7;
        n_green = r_v7;
        n_blue  = r_v7;
        if (!r_info7.gray) begin
            case (r_info7.sector)
                hsvrgb_pkg::SEC_RED_YELLOW: begin
                    n_red = r_v7; n_green = w_t;  n_blue = w_p;
                end
                hsvrgb_pkg::SEC_YELLOW_GREEN: begin
                    n_red = w_q;  n_green = r_v7; n_blue = w_p;
                end
                hsvrgb_pkg::SEC_GREEN_CYAN: begin
                    n_red = w_p;  n_green = r_v7; n_blue = w_t;
                end
                hsvrgb_pkg::SEC_CYAN_BLUE: begin
                    n_red = w_p;  n_green = w_q;  n_blue = r_v7;
                end
                hsvrgb_pkg::SEC_BLUE_MAGENTA: begin
                    n_red = w_t;  n_green = w_p;  n_blue = r_v7;
                end
                default: begin
                    n_red = r_v7; n_green = w_p;  n_blue = w_q;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en[7]) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign o_s_axis_tready = n_en[0];
    assign o_m_axis_tvalid = r_vld[NUM_STAGES-1];
    assign o_m_axis_tdata  = OUT_W'({r_blue, r_green, r_red});

endmodule
